FILE: design/memory_map_region_manager_macros.svh
// Assertion macros used by the region manager top level.
// Bodies are empty when SYNTHESIS is defined.
`ifndef MEMORY_MAP_REGION_MANAGER_MACROS_SVH
`define MEMORY_MAP_REGION_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
`define MMRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region manager assertion failed");
`define MMRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region manager assertion failed");
`else
`define MMRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MMRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/mmrm_pkg.sv
// Types, constants and state codes of the memory region manager.
// Used by the interfaces and the top level.
package mmrm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int PAGE_BYTES  = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W   = 3;
    localparam int ADDR_W   = 64;
    localparam int TYPE_W   = 16;
    localparam int ASIZE_W  = 32;
    localparam int ALOG_W   = 5;
    localparam int EIDX_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECLAIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 2'd2;

    localparam logic [TYPE_W-1:0]     USABLE_RESET  = 16'd1;
    localparam logic [TYPE_W-1:0]     RECLAIM_RESET = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] LOW_RESET     = 32'h0010_0000;

    localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SANITISE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NESTED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [TYPE_W-1:0] rtype;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   out_length;
        logic [TYPE_W-1:0]   out_type;
        logic [CNT_W-1:0]    entry_count;
    } t_result;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_RD_WAIT, S_DONE,
        S_SI_CHK, S_SI_RD, S_SJ_CHK, S_SJ_RD, S_SJ_CMP, S_SJ_UPD,
        S_SE_LEN, S_SE_CHK, S_FP_D, S_FP_L, S_FP_Z, S_FP_LO, S_FP_CL, S_FP_WR,
        S_DR_CHK, S_DR_RD,
        S_SO_CHK, S_SO_RDP, S_SO_JCHK, S_SO_JRD, S_SO_SW1, S_SO_SW2,
        S_MG_CHK, S_MG_RD0, S_MG_RD1, S_MG_DEC,
        S_RS_CHK, S_RS_RD, S_RS_CMP, S_RS_DEC, S_RS_ROOM, S_RS_TAIL, S_RS_NEW,
        S_AL_CHK, S_AL_RD, S_AL_TST, S_AL_FIT
    } t_state;

endpackage

FILE: design/mmrm_item_if.sv
// Input channel of the region manager: handshake and request fields.
// Depends on mmrm_pkg for field widths.
interface mmrm_item_if;
    logic                                valid;
    logic                                ready;
    logic [mmrm_pkg::MODE_W-1:0]         mode;
    logic [mmrm_pkg::ADDR_W-1:0]         region_base;
    logic [mmrm_pkg::ADDR_W-1:0]         region_length;
    logic [mmrm_pkg::TYPE_W-1:0]         region_type;
    logic [mmrm_pkg::ASIZE_W-1:0]        alloc_size;
    logic [mmrm_pkg::ALOG_W-1:0]         align_log2;
    logic                                page_align;
    logic [mmrm_pkg::EIDX_W-1:0]         entry_index;

    modport source (
        output valid, mode, region_base, region_length, region_type,
               alloc_size, align_log2, page_align, entry_index,
        input  ready
    );
    modport sink (
        input  valid, mode, region_base, region_length, region_type,
               alloc_size, align_log2, page_align, entry_index,
        output ready
    );
endinterface

FILE: design/mmrm_result_if.sv
// Output channel of the region manager: handshake and result fields.
// Depends on mmrm_pkg for field widths.
interface mmrm_result_if;
    logic                          valid;
    logic                          ready;
    logic [mmrm_pkg::STATUS_W-1:0] status;
    logic [mmrm_pkg::ADDR_W-1:0]   address;
    logic [mmrm_pkg::ADDR_W-1:0]   out_length;
    logic [mmrm_pkg::TYPE_W-1:0]   out_type;
    logic [mmrm_pkg::CNT_W-1:0]    entry_count;

    modport source (
        output valid, status, address, out_length, out_type, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, address, out_length, out_type, entry_count,
        output ready
    );
endinterface

FILE: design/memory_map_region_manager.sv
// Top level of the memory region manager: sequencer over one table RAM.
// Depends on mmrm_pkg, mmrm_item_if, mmrm_result_if, mmrm_ram and the macro header.
//
//   channel    direction  handshake          payload
//   i_item     in         valid/ready        mode, region fields, alloc, index
//   o_result   out        valid/ready        status, address, length, type, count
//   i_cfg_*    in         write enable only  register index, 32-bit data
//
// Reserve scans the table one entry after another.
// Sanitise is bound by the single RAM read port: an overlap scan over each usable entry,
// a selection sort, and a shift of the later entries on each removal all go through
// that one port, for a table of up to 256 entries.
// Reset clears the entry count and sets the config registers to their defaults; the table contents need no clearing.
// The block takes no item while one is in work; a finished result may wait for the sink.
`include "memory_map_region_manager_macros.svh"
module memory_map_region_manager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mmrm_item_if.sink                           i_item,
    mmrm_result_if.source                       o_result,
    input  logic                                i_cfg_we,
    input  logic [mmrm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mmrm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    localparam int CW = mmrm_pkg::CNT_W;
    localparam int IW = mmrm_pkg::IDX_W;

    mmrm_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic [mmrm_pkg::TYPE_W-1:0]     r_usable, r_reclaim;
    logic [mmrm_pkg::CFG_DATA_W-1:0] r_low;

    logic [mmrm_pkg::MODE_W-1:0]  r_mode, n_mode;
    logic [63:0]                  r_rb, n_rb, r_rl, n_rl, r_rt, n_rt;
    logic [mmrm_pkg::TYPE_W-1:0]  r_rtype, n_rtype;
    logic [mmrm_pkg::ASIZE_W-1:0] r_asize, n_asize;
    logic [mmrm_pkg::ALOG_W-1:0]  r_alog, n_alog;
    logic                         r_pal, n_pal, r_align, n_align;
    logic [mmrm_pkg::EIDX_W-1:0]  r_idx, n_idx;

    logic [CW-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j;
    logic [IW-1:0] r_m, n_m;
    logic [63:0]   r_b, n_b, r_t, n_t, r_l, n_l, r_ob, n_ob, r_ot, n_ot;
    logic          r_fa, n_fa, r_fb, n_fb;
    mmrm_pkg::t_entry r_ent, n_ent;

    logic [mmrm_pkg::STATUS_W-1:0] r_status, n_status;
    logic [63:0]                   r_addr, n_addr, r_olen, n_olen;
    logic [mmrm_pkg::TYPE_W-1:0]   r_otype, n_otype;

    mmrm_pkg::t_result r_out;
    logic              r_ovalid;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    mmrm_pkg::t_entry ram_wdata, w_rd;
    logic [mmrm_pkg::ENTRY_W-1:0] ram_rdata;

    logic [63:0]   w_low, w_nt, w_nb, w_amask;
    logic          w_rd_usable, w_i_lt, w_i1_lt, w_j_lt, w_j1_lt, w_al_skip, w_nofit;
    logic          w_merge, w_accept, w_out_free;
    logic [CW:0]   w_need;

    mmrm_ram #(
        .WIDTH (mmrm_pkg::ENTRY_W),
        .DEPTH (mmrm_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_rd        = mmrm_pkg::t_entry'(ram_rdata);
    assign w_low       = 64'(r_low);
    assign w_rd_usable = (w_rd.rtype == r_usable);
    assign w_i_lt      = (r_i < r_cnt);
    assign w_j_lt      = (r_j < r_cnt);
    assign w_i1_lt     = (({1'b0, r_i} + (CW+1)'(1)) < {1'b0, r_cnt});
    assign w_j1_lt     = (({1'b0, r_j} + (CW+1)'(1)) < {1'b0, r_cnt});
    assign w_nt        = r_fa ? r_ob : r_t;
    assign w_nb        = (r_ot >= r_b && r_ot < w_nt) ? r_ot : r_b;
    assign w_amask     = ~((64'd1 << r_alog) - 64'd1);
    assign w_al_skip   = (r_b[63:32] != 32'd0) || (r_l[63:32] != 32'd0) ||
                         (r_t[63:32] != 32'd0) || (64'(r_asize) > r_t);
    assign w_need      = {1'b0, r_cnt} - (CW+1)'(r_l == 64'd0)
                         + (CW+1)'(r_ob != 64'd0) + (CW+1)'(1);
    assign w_nofit     = (w_need > (CW+1)'(mmrm_pkg::TABLE_DEPTH));
    assign w_merge     = r_fa && (r_ob == r_t);
    assign w_accept    = i_item.valid && i_item.ready;
    assign w_out_free  = !r_ovalid || o_result.ready;

    assign i_item.ready         = (r_state == mmrm_pkg::S_IDLE);
    assign o_result.valid       = r_ovalid;
    assign o_result.status      = r_out.status;
    assign o_result.address     = r_out.address;
    assign o_result.out_length  = r_out.out_length;
    assign o_result.out_type    = r_out.out_type;
    assign o_result.entry_count = r_out.entry_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mmrm_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    n_state = mmrm_pkg::S_DISPATCH;
                end
            end
            mmrm_pkg::S_DISPATCH: begin
                case (r_mode)
                    mmrm_pkg::MODE_SANITISE: n_state = mmrm_pkg::S_SI_CHK;
                    mmrm_pkg::MODE_ALLOC:    n_state = mmrm_pkg::S_AL_CHK;
                    mmrm_pkg::MODE_RESERVE:  n_state = mmrm_pkg::S_RS_CHK;
                    mmrm_pkg::MODE_READ: begin
                        n_state = (CW'(r_idx) < r_cnt) ? mmrm_pkg::S_RD_WAIT
                                                       : mmrm_pkg::S_DONE;
                    end
                    default: n_state = mmrm_pkg::S_DONE;
                endcase
            end
            mmrm_pkg::S_RD_WAIT: n_state = mmrm_pkg::S_DONE;
            mmrm_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = mmrm_pkg::S_IDLE;
                end
            end
            mmrm_pkg::S_SI_CHK: n_state = w_i_lt ? mmrm_pkg::S_SI_RD : mmrm_pkg::S_SO_CHK;
            mmrm_pkg::S_SI_RD: n_state = w_rd_usable ? mmrm_pkg::S_SJ_CHK : mmrm_pkg::S_SI_CHK;
            mmrm_pkg::S_SJ_CHK: begin
                if (r_j == r_cnt) begin
                    n_state = mmrm_pkg::S_SE_LEN;
                end else if (r_j != r_i) begin
                    n_state = mmrm_pkg::S_SJ_RD;
                end
            end
            mmrm_pkg::S_SJ_RD:  n_state = mmrm_pkg::S_SJ_CMP;
            mmrm_pkg::S_SJ_CMP: n_state = mmrm_pkg::S_SJ_UPD;
            mmrm_pkg::S_SJ_UPD: n_state = (r_fa && r_fb) ? mmrm_pkg::S_DONE : mmrm_pkg::S_SJ_CHK;
            mmrm_pkg::S_SE_LEN: n_state = mmrm_pkg::S_SE_CHK;
            mmrm_pkg::S_SE_CHK: begin
                if (r_l == 64'd0) begin
                    n_state = mmrm_pkg::S_DR_CHK;
                end else if (!r_align) begin
                    n_state = mmrm_pkg::S_SI_CHK;
                end else if (r_l < 64'(mmrm_pkg::PAGE_BYTES)) begin
                    n_state = mmrm_pkg::S_DR_CHK;
                end else begin
                    n_state = mmrm_pkg::S_FP_D;
                end
            end
            mmrm_pkg::S_FP_D: n_state = mmrm_pkg::S_FP_L;
            mmrm_pkg::S_FP_L: n_state = mmrm_pkg::S_FP_Z;
            mmrm_pkg::S_FP_Z: n_state = (r_l == 64'd0) ? mmrm_pkg::S_DR_CHK : mmrm_pkg::S_FP_LO;
            mmrm_pkg::S_FP_LO: begin
                if (!r_fa) begin
                    n_state = mmrm_pkg::S_FP_WR;
                end else if (r_t > w_low) begin
                    n_state = mmrm_pkg::S_FP_CL;
                end else begin
                    n_state = mmrm_pkg::S_DR_CHK;
                end
            end
            mmrm_pkg::S_FP_CL: n_state = mmrm_pkg::S_FP_WR;
            mmrm_pkg::S_FP_WR: n_state = mmrm_pkg::S_SI_CHK;
            mmrm_pkg::S_DR_CHK: n_state = w_j1_lt ? mmrm_pkg::S_DR_RD : r_ret;
            mmrm_pkg::S_DR_RD:  n_state = mmrm_pkg::S_DR_CHK;
            mmrm_pkg::S_SO_CHK: n_state = w_i1_lt ? mmrm_pkg::S_SO_RDP : mmrm_pkg::S_MG_CHK;
            mmrm_pkg::S_SO_RDP: n_state = mmrm_pkg::S_SO_JCHK;
            mmrm_pkg::S_SO_JCHK: n_state = w_j_lt ? mmrm_pkg::S_SO_JRD : mmrm_pkg::S_SO_SW1;
            mmrm_pkg::S_SO_JRD: n_state = mmrm_pkg::S_SO_JCHK;
            mmrm_pkg::S_SO_SW1: n_state = mmrm_pkg::S_SO_SW2;
            mmrm_pkg::S_SO_SW2: n_state = mmrm_pkg::S_SO_CHK;
            mmrm_pkg::S_MG_CHK: n_state = w_i1_lt ? mmrm_pkg::S_MG_RD0 : mmrm_pkg::S_DONE;
            mmrm_pkg::S_MG_RD0: n_state = mmrm_pkg::S_MG_RD1;
            mmrm_pkg::S_MG_RD1: n_state = mmrm_pkg::S_MG_DEC;
            mmrm_pkg::S_MG_DEC: n_state = w_merge ? mmrm_pkg::S_DR_CHK : mmrm_pkg::S_MG_CHK;
            mmrm_pkg::S_RS_CHK: n_state = w_i_lt ? mmrm_pkg::S_RS_RD : mmrm_pkg::S_DONE;
            mmrm_pkg::S_RS_RD: n_state = w_rd_usable ? mmrm_pkg::S_RS_CMP : mmrm_pkg::S_RS_CHK;
            mmrm_pkg::S_RS_CMP: n_state = mmrm_pkg::S_RS_DEC;
            mmrm_pkg::S_RS_DEC: n_state = (r_fa && r_fb) ? mmrm_pkg::S_RS_ROOM : mmrm_pkg::S_RS_CHK;
            mmrm_pkg::S_RS_ROOM: begin
                if (w_nofit) begin
                    n_state = mmrm_pkg::S_DONE;
                end else if (r_l == 64'd0) begin
                    n_state = mmrm_pkg::S_DR_CHK;
                end else begin
                    n_state = mmrm_pkg::S_RS_TAIL;
                end
            end
            mmrm_pkg::S_RS_TAIL: n_state = mmrm_pkg::S_RS_NEW;
            mmrm_pkg::S_RS_NEW: begin
                n_state = (r_mode == mmrm_pkg::MODE_ALLOC) ? mmrm_pkg::S_SI_CHK : mmrm_pkg::S_DONE;
            end
            mmrm_pkg::S_AL_CHK: n_state = (r_i == CW'(0)) ? mmrm_pkg::S_DONE : mmrm_pkg::S_AL_RD;
            mmrm_pkg::S_AL_RD: n_state = w_rd_usable ? mmrm_pkg::S_AL_TST : mmrm_pkg::S_AL_CHK;
            mmrm_pkg::S_AL_TST: n_state = w_al_skip ? mmrm_pkg::S_AL_CHK : mmrm_pkg::S_AL_FIT;
            mmrm_pkg::S_AL_FIT: n_state = (r_ob < r_b) ? mmrm_pkg::S_AL_CHK : mmrm_pkg::S_RS_CHK;
            default: n_state = mmrm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_ret = r_ret;   n_mode = r_mode;   n_rb = r_rb;   n_rl = r_rl;   n_rt = r_rt;
        n_rtype = r_rtype; n_asize = r_asize; n_alog = r_alog; n_pal = r_pal;
        n_align = r_align; n_idx = r_idx;   n_cnt = r_cnt; n_i = r_i;     n_j = r_j;
        n_m = r_m;       n_b = r_b;         n_t = r_t;     n_l = r_l;     n_ob = r_ob;
        n_ot = r_ot;     n_fa = r_fa;       n_fb = r_fb;   n_ent = r_ent;
        n_status = r_status; n_addr = r_addr; n_olen = r_olen; n_otype = r_otype;
        ram_we    = 1'b0;
        ram_waddr = r_i[IW-1:0];
        ram_wdata = '{base: r_b, length: r_l, rtype: r_usable};
        ram_raddr = r_i[IW-1:0];
        case (r_state)
            mmrm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mode   = i_item.mode;
                    n_rb     = i_item.region_base;
                    n_rl     = i_item.region_length;
                    n_rtype  = i_item.region_type;
                    n_asize  = i_item.alloc_size;
                    n_alog   = i_item.align_log2;
                    n_pal    = i_item.page_align;
                    n_idx    = i_item.entry_index;
                    n_status = mmrm_pkg::ST_OK;
                    n_addr   = 64'd0;
                    n_olen   = 64'd0;
                    n_otype  = '0;
                end
            end
            mmrm_pkg::S_DISPATCH: begin
                n_i = CW'(0);
                case (r_mode)
                    mmrm_pkg::MODE_APPEND: begin
                        if (r_cnt >= CW'(mmrm_pkg::TABLE_DEPTH)) begin
                            n_status = mmrm_pkg::ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_cnt[IW-1:0];
                            ram_wdata = '{base: r_rb, length: r_rl, rtype: r_rtype};
                            n_cnt     = r_cnt + CW'(1);
                        end
                    end
                    mmrm_pkg::MODE_SANITISE: n_align = r_pal;
                    mmrm_pkg::MODE_ALLOC:    n_i = r_cnt;
                    mmrm_pkg::MODE_RESERVE:  n_rt = r_rb + r_rl;
                    mmrm_pkg::MODE_READ: begin
                        ram_raddr = r_idx[IW-1:0];
                        if (CW'(r_idx) >= r_cnt) begin
                            n_status = mmrm_pkg::ST_BAD_INDEX;
                        end
                    end
                    default: n_i = CW'(0);
                endcase
            end
            mmrm_pkg::S_RD_WAIT: begin
                n_addr  = w_rd.base;
                n_olen  = w_rd.length;
                n_otype = w_rd.rtype;
            end
            mmrm_pkg::S_SI_CHK: begin
                if (!w_i_lt) begin
                    n_i = CW'(0);
                end
            end
            mmrm_pkg::S_SI_RD: begin
                if (w_rd_usable) begin
                    n_b = w_rd.base;
                    n_t = w_rd.base + w_rd.length;
                    n_j = CW'(0);
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            mmrm_pkg::S_SJ_CHK: begin
                ram_raddr = r_j[IW-1:0];
                if (r_j != r_cnt && r_j == r_i) begin
                    n_j = r_j + CW'(1);
                end
            end
            mmrm_pkg::S_SJ_RD: begin
                n_ob = w_rd.base;
                n_ot = w_rd.base + w_rd.length;
            end
            mmrm_pkg::S_SJ_CMP: begin
                n_fa = (r_ob >= r_b) && (r_ob < r_t);
                n_fb = (r_ot >= r_b) && (r_ot < r_t);
            end
            mmrm_pkg::S_SJ_UPD: begin
                if (r_fa && r_fb) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{base: r_b, length: r_t - r_b, rtype: r_usable};
                    n_status  = mmrm_pkg::ST_NESTED;
                end else begin
                    n_t = w_nt;
                    n_b = w_nb;
                    n_j = r_j + CW'(1);
                end
            end
            mmrm_pkg::S_SE_LEN: n_l = r_t - r_b;
            mmrm_pkg::S_SE_CHK: begin
                n_j   = r_i;
                n_ret = mmrm_pkg::S_SI_CHK;
                if (r_l != 64'd0 && !r_align) begin
                    ram_we = 1'b1;
                    n_i    = r_i + CW'(1);
                end
                n_ob = (r_b + mmrm_pkg::PAGE_MASK) & ~mmrm_pkg::PAGE_MASK;
            end
            mmrm_pkg::S_FP_D: n_ot = r_ob - r_b;
            mmrm_pkg::S_FP_L: begin
                n_l = (r_l - r_ot) & ~mmrm_pkg::PAGE_MASK;
                n_b = r_ob;
            end
            mmrm_pkg::S_FP_Z: begin
                n_t  = r_b + r_l;
                n_fa = (r_b < w_low);
                n_j  = r_i;
            end
            mmrm_pkg::S_FP_LO: begin
                n_ot = w_low - r_b;
                n_j  = r_i;
            end
            mmrm_pkg::S_FP_CL: begin
                n_l = r_l - r_ot;
                n_b = w_low;
            end
            mmrm_pkg::S_FP_WR: begin
                ram_we = 1'b1;
                n_i    = r_i + CW'(1);
            end
            mmrm_pkg::S_DR_CHK: begin
                ram_raddr = IW'(r_j + CW'(1));
                if (!w_j1_lt) begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            mmrm_pkg::S_DR_RD: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IW-1:0];
                ram_wdata = w_rd;
                n_j       = r_j + CW'(1);
            end
            mmrm_pkg::S_SO_CHK: begin
                if (!w_i1_lt) begin
                    n_i = CW'(0);
                end
            end
            mmrm_pkg::S_SO_RDP: begin
                n_ent = w_rd;
                n_m   = r_i[IW-1:0];
                n_j   = r_i + CW'(1);
            end
            mmrm_pkg::S_SO_JCHK: begin
                if (w_j_lt) begin
                    ram_raddr = r_j[IW-1:0];
                end
            end
            mmrm_pkg::S_SO_JRD: begin
                if (w_rd.base < r_ent.base) begin
                    n_ent = w_rd;
                    n_m   = r_j[IW-1:0];
                end
                n_j = r_j + CW'(1);
            end
            mmrm_pkg::S_SO_SW1: begin
                ram_we    = 1'b1;
                ram_waddr = r_m;
                ram_wdata = w_rd;
            end
            mmrm_pkg::S_SO_SW2: begin
                ram_we    = 1'b1;
                ram_wdata = r_ent;
                n_i       = r_i + CW'(1);
            end
            mmrm_pkg::S_MG_RD0: begin
                n_ent     = w_rd;
                ram_raddr = IW'(r_i + CW'(1));
            end
            mmrm_pkg::S_MG_RD1: begin
                n_fa = (r_ent.rtype == r_reclaim) && (w_rd.rtype == r_reclaim);
                n_ob = w_rd.base;
                n_l  = w_rd.length;
                n_t  = r_ent.base + r_ent.length;
            end
            mmrm_pkg::S_MG_DEC: begin
                if (w_merge) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{base: r_ent.base, length: r_ent.length + r_l,
                                  rtype: r_ent.rtype};
                    n_j       = r_i + CW'(1);
                    n_ret     = mmrm_pkg::S_MG_CHK;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            mmrm_pkg::S_RS_CHK: begin
                if (!w_i_lt) begin
                    n_status = mmrm_pkg::ST_OOM;
                end
            end
            mmrm_pkg::S_RS_RD: begin
                n_ent = w_rd;
                n_t   = w_rd.base + w_rd.length;
                if (!w_rd_usable) begin
                    n_i = r_i + CW'(1);
                end
            end
            mmrm_pkg::S_RS_CMP: begin
                n_fa = (r_rb >= r_ent.base) && (r_rb < r_t);
                n_fb = (r_rt >= r_ent.base) && (r_rt <= r_t);
            end
            mmrm_pkg::S_RS_DEC: begin
                if (r_fa && r_fb) begin
                    n_l  = r_rb - r_ent.base;
                    n_ob = r_t - r_rt;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            mmrm_pkg::S_RS_ROOM: begin
                n_j   = r_i;
                n_ret = mmrm_pkg::S_RS_TAIL;
                if (w_nofit) begin
                    n_status = mmrm_pkg::ST_FULL;
                end else if (r_l != 64'd0) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{base: r_ent.base, length: r_l, rtype: r_ent.rtype};
                end
            end
            mmrm_pkg::S_RS_TAIL: begin
                if (r_ob != 64'd0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt[IW-1:0];
                    ram_wdata = '{base: r_rt, length: r_ob, rtype: r_usable};
                    n_cnt     = r_cnt + CW'(1);
                end
            end
            mmrm_pkg::S_RS_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[IW-1:0];
                ram_wdata = '{base: r_rb, length: r_rl, rtype: r_rtype};
                n_cnt     = r_cnt + CW'(1);
                n_i       = CW'(0);
                n_align   = 1'b0;
                if (r_mode == mmrm_pkg::MODE_ALLOC) begin
                    n_addr = r_rb;
                end
            end
            mmrm_pkg::S_AL_CHK: begin
                ram_raddr = IW'(r_i - CW'(1));
                if (r_i == CW'(0)) begin
                    n_status = mmrm_pkg::ST_OOM;
                end else begin
                    n_i = r_i - CW'(1);
                end
            end
            mmrm_pkg::S_AL_RD: begin
                n_b = w_rd.base;
                n_l = w_rd.length;
                n_t = w_rd.base + w_rd.length;
            end
            mmrm_pkg::S_AL_TST: n_ob = (r_t - 64'(r_asize)) & w_amask;
            mmrm_pkg::S_AL_FIT: begin
                n_rb = r_ob;
                n_rl = r_t - r_ob;
                n_rt = r_t;
                if (r_ob >= r_b) begin
                    n_i = CW'(0);
                end
            end
            default: n_ret = r_ret;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mmrm_pkg::S_IDLE;
            r_ret     <= mmrm_pkg::S_IDLE;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_usable  <= mmrm_pkg::USABLE_RESET;
            r_reclaim <= mmrm_pkg::RECLAIM_RESET;
            r_low     <= mmrm_pkg::LOW_RESET;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            if (r_state == mmrm_pkg::S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mmrm_pkg::CFG_USABLE:  r_usable  <= i_cfg_wdata[mmrm_pkg::TYPE_W-1:0];
                    mmrm_pkg::CFG_RECLAIM: r_reclaim <= i_cfg_wdata[mmrm_pkg::TYPE_W-1:0];
                    mmrm_pkg::CFG_LOW:     r_low     <= i_cfg_wdata;
                    default:               r_low     <= r_low;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;   r_rb <= n_rb;   r_rl <= n_rl;   r_rt <= n_rt;
        r_rtype <= n_rtype; r_asize <= n_asize; r_alog <= n_alog; r_pal <= n_pal;
        r_align <= n_align; r_idx <= n_idx; r_i <= n_i;     r_j <= n_j;
        r_m <= n_m;         r_b <= n_b;     r_t <= n_t;     r_l <= n_l;
        r_ob <= n_ob;       r_ot <= n_ot;   r_fa <= n_fa;   r_fb <= n_fb;
        r_ent <= n_ent;     r_status <= n_status; r_addr <= n_addr;
        r_olen <= n_olen;   r_otype <= n_otype;
        if (r_state == mmrm_pkg::S_DONE && w_out_free) begin
            r_out <= '{status: r_status, address: r_addr, out_length: r_olen,
                       out_type: r_otype, entry_count: r_cnt};
        end
    end

    `MMRM_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(mmrm_pkg::TABLE_DEPTH))
    `MMRM_ASSERT_IMP(a_cnt_step, i_clk, i_rst_n, 1'b1, n_cnt == r_cnt || n_cnt == r_cnt + CW'(1) || n_cnt == r_cnt - CW'(1))
    `MMRM_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == mmrm_pkg::S_IDLE || r_state == mmrm_pkg::S_DONE, !ram_we)
    `MMRM_ASSERT_NXT(a_idle_cnt_hold, i_clk, i_rst_n, r_state == mmrm_pkg::S_IDLE, r_cnt == $past(r_cnt))
    `MMRM_ASSERT_NXT(a_done_posts, i_clk, i_rst_n, r_state == mmrm_pkg::S_DONE && w_out_free, r_ovalid)
endmodule

FILE: design/mmrm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mmrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
